@@ rtl/core/phl_pkg.sv @@
// Package for the positional handle list.
// Holds the operation and result word types, operation kinds and status codes.
// Used by positional_handle_list; depends on nothing.
package phl_pkg;

	localparam int KindW   = 3;
	localparam int PosW    = 7;
	localparam int HandleW = 10;
	localparam int StatusW = 2;
	localparam int LengthW = 7;

	localparam logic [KindW-1:0] KIND_INS_HEAD = 3'd0;
	localparam logic [KindW-1:0] KIND_INS_TAIL = 3'd1;
	localparam logic [KindW-1:0] KIND_INS_POS  = 3'd2;
	localparam logic [KindW-1:0] KIND_REM_HEAD = 3'd3;
	localparam logic [KindW-1:0] KIND_REM_TAIL = 3'd4;
	localparam logic [KindW-1:0] KIND_REM_POS  = 3'd5;

	localparam logic [StatusW-1:0] ST_DONE    = 2'd0;
	localparam logic [StatusW-1:0] ST_EMPTY   = 2'd1;
	localparam logic [StatusW-1:0] ST_FULL    = 2'd2;
	localparam logic [StatusW-1:0] ST_IGNORED = 2'd3;

	typedef struct packed {
		logic [KindW-1:0]   kind;
		logic [PosW-1:0]    position;
		logic [HandleW-1:0] record_handle;
	} op_t;

	typedef struct packed {
		logic [HandleW-1:0] removed_handle;
		logic [StatusW-1:0] status;
		logic [LengthW-1:0] list_length;
	} res_t;

endpackage

@@ rtl/core/positional_handle_list.sv @@
// Top level of the positional handle list: an ordered list of record handles.
// Each cell shifts in parallel by comparing its index with the target position.
// Depends on phl_pkg for the word types, kinds and status codes.
//
//   channel | direction | handshake              | word
//   op      | in        | op_valid / op_stall    | phl_pkg::op_t
//   res     | out       | res_valid / res_stall  | phl_pkg::res_t
//
// An operation word is registered in op_s1 on acceptance, applied to the cells
// from there and its result registered in res_q when that stage advances; one
// word is taken in every cycle while op_stall stays low.
// Reset clears the entry count; the cells hold no reset value.
// A stalled result holds the stage behind it, and op_stall rises only when
// that stage is full and cannot move forward.
module positional_handle_list #(
	parameter int LIST_DEPTH = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           op_valid,
	output logic           op_stall,
	input  phl_pkg::op_t   op,
	output logic           res_valid,
	input  logic           res_stall,
	output phl_pkg::res_t  res
);

	localparam int CntW = $clog2(LIST_DEPTH + 1);
	localparam int LW   = (CntW > phl_pkg::PosW) ? CntW : phl_pkg::PosW;

	logic                        valid_s1;
	phl_pkg::op_t                op_s1;
	logic                        adv;
	logic [CntW-1:0]             count_q;
	logic [CntW-1:0]             count_d;
	logic [phl_pkg::HandleW-1:0] slot_q [LIST_DEPTH];
	logic [phl_pkg::HandleW-1:0] slot_d [LIST_DEPTH];
	logic [LW-1:0]               cnt_x;
	logic [LW-1:0]               tgt;
	logic                        is_ins;
	logic                        is_rem;
	logic                        ins_do;
	logic                        rem_do;
	logic [phl_pkg::StatusW-1:0] status;
	logic [phl_pkg::HandleW-1:0] removed;
	phl_pkg::res_t               res_q;
	logic                        res_valid_q;

	assign adv      = valid_s1 && (!res_valid_q || !res_stall);
	assign op_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!op_stall) begin
			valid_s1 <= op_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (op_valid && !op_stall) begin
			op_s1 <= op;
		end
	end

	assign cnt_x = LW'(count_q);

	always_comb begin
		is_ins = 1'b0;
		is_rem = 1'b0;
		tgt    = '0;
		case (op_s1.kind)
			phl_pkg::KIND_INS_HEAD: begin
				is_ins = 1'b1;
			end
			phl_pkg::KIND_INS_TAIL: begin
				is_ins = 1'b1;
				tgt    = cnt_x;
			end
			phl_pkg::KIND_INS_POS: begin
				is_ins = 1'b1;
				tgt    = LW'(op_s1.position);
			end
			phl_pkg::KIND_REM_HEAD: begin
				is_rem = 1'b1;
			end
			phl_pkg::KIND_REM_TAIL: begin
				is_rem = 1'b1;
				tgt    = cnt_x - LW'(1);
			end
			phl_pkg::KIND_REM_POS: begin
				is_rem = 1'b1;
				tgt    = LW'(op_s1.position);
			end
			default: begin
				is_ins = 1'b0;
				is_rem = 1'b0;
			end
		endcase
	end

	always_comb begin
		status = phl_pkg::ST_DONE;
		ins_do = 1'b0;
		rem_do = 1'b0;
		if (is_ins) begin
			if (tgt > cnt_x) begin
				status = phl_pkg::ST_IGNORED;
			end else if (count_q == CntW'(LIST_DEPTH)) begin
				status = phl_pkg::ST_FULL;
			end else begin
				ins_do = 1'b1;
			end
		end else if (is_rem) begin
			if (count_q == '0 || tgt >= cnt_x) begin
				status = phl_pkg::ST_EMPTY;
			end else begin
				rem_do = 1'b1;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < LIST_DEPTH; i++) begin
			slot_d[i] = slot_q[i];
			if (ins_do) begin
				if (LW'(i) == tgt) begin
					slot_d[i] = op_s1.record_handle;
				end else if (i > 0 && LW'(i) > tgt) begin
					slot_d[i] = slot_q[(i > 0) ? i - 1 : 0];
				end
			end else if (rem_do) begin
				if (i < LIST_DEPTH - 1 && LW'(i) >= tgt) begin
					slot_d[i] = slot_q[(i < LIST_DEPTH - 1) ? i + 1 : i];
				end
			end
		end
	end

	always_comb begin
		removed = '0;
		for (int i = 0; i < LIST_DEPTH; i++) begin
			if (rem_do && LW'(i) == tgt) begin
				removed = removed | slot_q[i];
			end
		end
	end

	always_comb begin
		count_d = count_q;
		if (ins_do) begin
			count_d = count_q + CntW'(1);
		end else if (rem_do) begin
			count_d = count_q - CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < LIST_DEPTH; i++) begin
				slot_q[i] <= slot_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				count_q <= count_d;
			end
			if (adv) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.removed_handle <= removed;
			res_q.status         <= status;
			res_q.list_length    <= phl_pkg::LengthW'(LW'(count_d));
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
